// ----- src/piecewise_linear_interpolator_macros.svh -----
// Assertion macros for the piecewise linear interpolator.
// Used by the top level; no other dependencies.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/pli_pkg.sv -----
// Shared types and codes for the piecewise linear interpolator.
// No dependencies.
package pli_pkg;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_INSERT   = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LOW   = 3'd1;
  localparam logic [2:0] ST_HIGH  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;

  localparam int unsigned MdWidth = 33;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SCMP, S_SHIFT, S_SHWR, S_INSWR,
    S_QSEL, S_QEDGE0, S_QEDGEH, S_QB, S_QA, S_QMD, S_DONE
  } pli_state_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_MUL, MD_DIV
  } pli_md_state_t;

endpackage

// ----- src/pli_table_mem.sv -----
// Breakpoint store: one write port, one read port with registered data.
// Each word holds x in the upper half and y in the lower half.
module pli_table_mem #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [63:0]                    wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [63:0]                    rd_data
);

  logic [63:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/pli_muldiv.sv -----
// Serial unit computing (num * mag) / span, one bit per cycle for each phase.
// Depends on pli_pkg; num is below span, so the quotient fits 33 bits.
module pli_muldiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pli_pkg::MdWidth-1:0]    num,
  input  logic [pli_pkg::MdWidth-1:0]    mag,
  input  logic [pli_pkg::MdWidth-1:0]    span,
  output logic                           done,
  output logic [pli_pkg::MdWidth-1:0]    quo
);

  localparam int unsigned W = pli_pkg::MdWidth;

  pli_pkg::pli_md_state_t state_r, state_nxt;
  logic [2*W-1:0]         acc_r, acc_nxt;
  logic [W-1:0]           mcand_r, mcand_nxt;
  logic [W-1:0]           div_r, div_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [W:0]             psum;
  logic [W:0]             trial;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pli_pkg::MD_IDLE: if (start) state_nxt = pli_pkg::MD_MUL;
      pli_pkg::MD_MUL:  if (cnt_r == 6'(W - 1)) state_nxt = pli_pkg::MD_DIV;
      pli_pkg::MD_DIV:  if (cnt_r == 6'(W - 1)) state_nxt = pli_pkg::MD_IDLE;
      default:          state_nxt = pli_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    psum      = {1'b0, acc_r[2*W-1:W]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
    trial     = {acc_r[2*W-1:W], acc_r[W-1]};
    unique case (state_r)
      pli_pkg::MD_IDLE: begin
        if (start) begin
          acc_nxt   = {{W{1'b0}}, num};
          mcand_nxt = mag;
          div_nxt   = span;
          cnt_nxt   = '0;
        end
      end
      pli_pkg::MD_MUL: begin
        acc_nxt = {psum, acc_r[W-1:1]};
        cnt_nxt = (cnt_r == 6'(W - 1)) ? '0 : cnt_r + 6'd1;
      end
      pli_pkg::MD_DIV: begin
        if (trial >= {1'b0, div_r}) begin
          acc_nxt = {W'(trial - {1'b0, div_r}), acc_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = {trial[W-1:0], acc_r[W-2:0], 1'b0};
        end
        cnt_nxt  = cnt_r + 6'd1;
        done_nxt = (cnt_r == 6'(W - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pli_pkg::MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r[W-1:0];

endmodule

// ----- src/piecewise_linear_interpolator.sv -----
// Top level of the piecewise linear interpolator: control sequencer and output register.
// Depends on pli_pkg, pli_table_mem, pli_muldiv and the assertion macro header.
//
//   channel | ports                                          | direction
//   in      | in_valid in_stall in_command in_key in_value   | into block
//   out     | out_valid out_stall out_result out_status out_point_count | out of block
//
// Clear, full insert and empty query go straight to the done state. Insert runs a binary
// search, then reads and writes each entry moved, then writes the new entry.
// Query runs the same search and fetches the neighbours; for a key between two breakpoints
// it goes through the serial multiply and divide. Every command then loads the output.
// Reset clears the count, the sequencer state and out_valid; the table itself is not cleared.
// A result waiting under out_stall does not block the next transaction being taken.
`include "piecewise_linear_interpolator_macros.svh"
module piecewise_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic [2:0]         out_status,
  output logic [6:0]         out_point_count
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned W  = pli_pkg::MdWidth;

  pli_pkg::pli_state_t state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic signed [31:0] xb_r, xb_nxt;
  logic signed [31:0] ya_r, ya_nxt;
  logic               ge_r, ge_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [2:0]         st_r, st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_result_r, out_result_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [6:0]         out_count_r, out_count_nxt;

  logic               in_fire;
  logic               out_free;
  logic [CW:0]        mid_sum;
  logic [AW-1:0]      mid_w;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [63:0]        mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [63:0]        mem_rdata;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic               md_start;
  logic [W-1:0]       md_num;
  logic [W-1:0]       md_mag;
  logic [W-1:0]       md_span;
  logic               md_done;
  logic [W-1:0]       md_quo;
  logic signed [W-1:0] ydiff;
  logic signed [34:0] interp;

  assign in_stall = (state_r != pli_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w    = mid_sum[AW:1];
  assign rd_x     = $signed(mem_rdata[63:32]);
  assign rd_y     = $signed(mem_rdata[31:0]);
  assign md_num   = W'({key_r[31], key_r} - {rd_x[31], rd_x});
  assign md_span  = W'({xb_r[31], xb_r} - {rd_x[31], rd_x});
  assign ydiff    = $signed({val_r[31], val_r}) - $signed({rd_y[31], rd_y});
  assign interp   = ge_r ? ($signed({{3{ya_r[31]}}, ya_r}) + $signed({2'b00, md_quo}))
                         : ($signed({{3{ya_r[31]}}, ya_r}) - $signed({2'b00, md_quo}));

  pli_table_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  pli_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .num   (md_num),
    .mag   (md_mag),
    .span  (md_span),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pli_pkg::S_IDLE: begin
        if (in_fire) begin
          priority if (in_command == pli_pkg::CMD_INSERT
                       && count_r < CW'(TABLE_DEPTH)) begin
            state_nxt = pli_pkg::S_SEARCH;
          end else if (in_command == pli_pkg::CMD_QUERY && count_r != '0) begin
            state_nxt = pli_pkg::S_SEARCH;
          end else begin
            state_nxt = pli_pkg::S_DONE;
          end
        end
      end
      pli_pkg::S_SEARCH: begin
        priority if (lo_r < hi_r)                  state_nxt = pli_pkg::S_SCMP;
        else if (cmd_r == pli_pkg::CMD_INSERT)    state_nxt = pli_pkg::S_SHIFT;
        else                                      state_nxt = pli_pkg::S_QSEL;
      end
      pli_pkg::S_SCMP:  state_nxt = pli_pkg::S_SEARCH;
      pli_pkg::S_SHIFT: state_nxt = (i_r > lo_r) ? pli_pkg::S_SHWR : pli_pkg::S_INSWR;
      pli_pkg::S_SHWR:  state_nxt = pli_pkg::S_SHIFT;
      pli_pkg::S_INSWR: state_nxt = pli_pkg::S_DONE;
      pli_pkg::S_QSEL: begin
        priority if (lo_r == '0)      state_nxt = pli_pkg::S_QEDGE0;
        else if (lo_r >= count_r)     state_nxt = pli_pkg::S_QEDGEH;
        else                          state_nxt = pli_pkg::S_QB;
      end
      pli_pkg::S_QEDGE0: state_nxt = pli_pkg::S_DONE;
      pli_pkg::S_QEDGEH: state_nxt = pli_pkg::S_DONE;
      pli_pkg::S_QB:     state_nxt = (rd_x == key_r) ? pli_pkg::S_DONE : pli_pkg::S_QA;
      pli_pkg::S_QA:     state_nxt = pli_pkg::S_QMD;
      pli_pkg::S_QMD:    if (md_done) state_nxt = pli_pkg::S_DONE;
      pli_pkg::S_DONE:   if (out_free) state_nxt = pli_pkg::S_IDLE;
      default:           state_nxt = pli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    i_nxt          = i_r;
    xb_nxt         = xb_r;
    ya_nxt         = ya_r;
    ge_nxt         = ge_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_waddr      = i_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = mid_w;
    md_start       = 1'b0;
    md_mag         = ydiff[W-1] ? W'(-ydiff) : W'(ydiff);
    unique case (state_r)
      pli_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_command;
          key_nxt = in_key;
          val_nxt = in_value;
          res_nxt = '0;
          st_nxt  = pli_pkg::ST_OK;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          unique case (in_command)
            pli_pkg::CMD_CLEAR:  count_nxt = '0;
            pli_pkg::CMD_INSERT: if (count_r >= CW'(TABLE_DEPTH)) st_nxt = pli_pkg::ST_FULL;
            pli_pkg::CMD_QUERY:  if (count_r == '0) st_nxt = pli_pkg::ST_EMPTY;
            default: ;
          endcase
        end
      end
      pli_pkg::S_SEARCH: begin
        if (lo_r < hi_r) begin
          mem_re  = 1'b1;
          mid_nxt = mid_w;
        end
        i_nxt = count_r;
      end
      pli_pkg::S_SCMP: begin
        if ((cmd_r == pli_pkg::CMD_INSERT) ? (rd_x <= key_r) : (rd_x < key_r)) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
      end
      pli_pkg::S_SHIFT: begin
        mem_re    = (i_r > lo_r);
        mem_raddr = AW'(i_r - CW'(1));
      end
      pli_pkg::S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[AW-1:0];
        mem_wdata = mem_rdata;
        i_nxt     = i_r - CW'(1);
      end
      pli_pkg::S_INSWR: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r[AW-1:0];
        mem_wdata = {key_r, val_r};
        count_nxt = count_r + CW'(1);
      end
      pli_pkg::S_QSEL: begin
        mem_re = 1'b1;
        priority if (lo_r == '0)  mem_raddr = '0;
        else if (lo_r >= count_r) mem_raddr = AW'(count_r - CW'(1));
        else                      mem_raddr = lo_r[AW-1:0];
      end
      pli_pkg::S_QEDGE0: begin
        res_nxt = rd_y;
        st_nxt  = (key_r < rd_x) ? pli_pkg::ST_LOW : pli_pkg::ST_OK;
      end
      pli_pkg::S_QEDGEH: begin
        res_nxt = rd_y;
        st_nxt  = pli_pkg::ST_HIGH;
      end
      pli_pkg::S_QB: begin
        res_nxt   = rd_y;
        xb_nxt    = rd_x;
        val_nxt   = rd_y;
        mem_re    = 1'b1;
        mem_raddr = AW'(lo_r - CW'(1));
      end
      pli_pkg::S_QA: begin
        md_start = 1'b1;
        ya_nxt   = rd_y;
        ge_nxt   = !ydiff[W-1];
      end
      pli_pkg::S_QMD: begin
        if (md_done) begin
          priority if (interp > 35'sd2147483647) begin
            res_nxt = 32'sh7FFFFFFF;
            st_nxt  = pli_pkg::ST_SAT;
          end else if (interp < -35'sd2147483648) begin
            res_nxt = 32'sh80000000;
            st_nxt  = pli_pkg::ST_SAT;
          end else begin
            res_nxt = interp[31:0];
            st_nxt  = pli_pkg::ST_OK;
          end
        end
      end
      pli_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_r;
          out_status_nxt = st_r;
          out_count_nxt  = 7'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pli_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    i_r          <= i_nxt;
    xb_r         <= xb_nxt;
    ya_r         <= ya_nxt;
    ge_r         <= ge_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_status      = out_status_r;
  assign out_point_count = out_count_r;

  `PLI_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(TABLE_DEPTH))
  `PLI_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire, state_r != pli_pkg::S_IDLE)
  `PLI_ASSERT_IMPL(a_md_done_in_wait, clk, rst_n, md_done, state_r == pli_pkg::S_QMD)
  `PLI_ASSERT_NEXT(a_done_loads_output, clk, rst_n,
                   state_r == pli_pkg::S_DONE && out_free, out_valid_r)

endmodule

// ----- dv/tb_piecewise_linear_interpolator.sv -----
// Testbench for the piecewise linear interpolator: directed and random transactions.
// Depends on pli_pkg and the piecewise_linear_interpolator top level.
`timescale 1ns / 100ps
module tb_piecewise_linear_interpolator;

  localparam int Depth = 64;
  localparam int WatchLimit = 20000;
  localparam int DueDepth = 4096;

  typedef struct packed {
    logic signed [31:0] result;
    logic [2:0]         status;
    logic [6:0]         point_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = pli_pkg::CMD_CLEAR;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result;
  logic [2:0] out_status;
  logic [6:0] out_point_count;

  logic signed [31:0] tbl_x [Depth];
  logic signed [31:0] tbl_y [Depth];
  int held;
  answer_t answers_due [DueDepth];
  int due_wr = 0;
  int due_rd = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  piecewise_linear_interpolator #(.TABLE_DEPTH(Depth)) uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic answer_t interpolate(logic [1:0] cmd, logic signed [31:0] k,
                                          logic signed [31:0] v);
    answer_t a;
    int p;
    longint xa, xb, ya, yb, res;
    longint unsigned num, span, mag, quo;
    a.result = '0;
    a.status = pli_pkg::ST_OK;
    if (cmd == pli_pkg::CMD_CLEAR) begin
      held = 0;
    end else if (cmd == pli_pkg::CMD_INSERT) begin
      if (held >= Depth) begin
        a.status = pli_pkg::ST_FULL;
      end else begin
        p = 0;
        while (p < held && tbl_x[p] <= k) p++;
        for (int i = held; i > p; i--) begin
          tbl_x[i] = tbl_x[i-1];
          tbl_y[i] = tbl_y[i-1];
        end
        tbl_x[p] = k;
        tbl_y[p] = v;
        held++;
      end
    end else if (cmd == pli_pkg::CMD_QUERY) begin
      if (held == 0) begin
        a.status = pli_pkg::ST_EMPTY;
      end else begin
        p = 0;
        while (p < held && tbl_x[p] < k) p++;
        if (p == 0) begin
          a.status = (k < tbl_x[0]) ? pli_pkg::ST_LOW : pli_pkg::ST_OK;
          a.result = tbl_y[0];
        end else if (p >= held) begin
          a.status = pli_pkg::ST_HIGH;
          a.result = tbl_y[held-1];
        end else if (tbl_x[p] == k) begin
          a.result = tbl_y[p];
        end else begin
          xa = tbl_x[p-1];
          xb = tbl_x[p];
          ya = tbl_y[p-1];
          yb = tbl_y[p];
          num = longint'(k) - xa;
          span = xb - xa;
          mag = (yb >= ya) ? yb - ya : ya - yb;
          quo = (span != 0) ? (num * mag) / span : 0;
          res = (yb >= ya) ? ya + longint'(quo) : ya - longint'(quo);
          if (res > 64'sd2147483647) begin
            res = 64'sd2147483647;
            a.status = pli_pkg::ST_SAT;
          end else if (res < -64'sd2147483648) begin
            res = -64'sd2147483648;
            a.status = pli_pkg::ST_SAT;
          end
          a.result = res[31:0];
        end
      end
    end
    a.point_count = held[6:0];
    return a;
  endfunction

  task automatic send_item(logic [1:0] cmd, logic signed [31:0] k, logic signed [31:0] v);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= k;
    in_value <= v;
    answers_due[due_wr % DueDepth] = interpolate(cmd, k, v);
    due_wr++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_rd != due_wr) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom());
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && gaps_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.result = out_result;
      got.status = out_status;
      got.point_count = out_point_count;
      if (due_rd == due_wr) begin
        $display("%0t unexpected transaction: actual %h", $time, got);
        errors++;
      end else begin
        want = answers_due[due_rd % DueDepth];
        due_rd++;
        if (got.result !== want.result || got.status !== want.status ||
            got.point_count !== want.point_count) begin
          $display("%0t mismatch: expected result %h status %0d count %0d, actual %h %0d %0d",
                   $time, want.result, want.status, want.point_count,
                   got.result, got.status, got.point_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_left > 0) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    send_item(pli_pkg::CMD_QUERY, 32'sd0, 32'sd0);
    send_item(pli_pkg::CMD_INSERT, 32'sh00010000, 32'sh00020000);
    send_item(pli_pkg::CMD_QUERY, 32'sh00010000, 32'sd0);
    send_item(pli_pkg::CMD_QUERY, 32'sh80000000, 32'sd0);
    send_item(pli_pkg::CMD_QUERY, 32'sh7fffffff, 32'sd0);
    send_item(pli_pkg::CMD_INSERT, 32'sh00010000, 32'sh00050000);
    send_item(pli_pkg::CMD_QUERY, 32'sh00010000, 32'sd0);
    send_item(pli_pkg::CMD_INSERT, 32'sh80000000, 32'sh7fffffff);
    send_item(pli_pkg::CMD_INSERT, 32'sh7fffffff, 32'sh80000000);
    send_item(pli_pkg::CMD_QUERY, 32'sd0, 32'sd0);
    send_item(pli_pkg::CMD_QUERY, 32'sh40000000, 32'sd0);
    send_item(pli_pkg::CMD_QUERY, 32'sh7ffffffe, 32'sd0);
    send_item(pli_pkg::CMD_RESERVED, 32'sh7fffffff, 32'sh7fffffff);
    send_item(pli_pkg::CMD_CLEAR, 32'sh7fffffff, 32'shffffffff);
    send_item(pli_pkg::CMD_QUERY, 32'sd5, 32'sd0);
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < Depth + 3; i++)
      send_item(pli_pkg::CMD_INSERT, rand_word(), rand_word());
    for (int i = 0; i < 10; i++) send_item(pli_pkg::CMD_QUERY, rand_word(), rand_word());
    send_item(pli_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_left = 400;
        wait (hold_left == 0);
      end
      for (int i = 0; i < 12; i++) send_item(pli_pkg::CMD_INSERT, rand_word(), rand_word());
    join
    wait_drained();
  endtask

  task automatic test_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      if (i > n - 150) gaps_on = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 2) send_item(pli_pkg::CMD_CLEAR, $signed($urandom()), $signed($urandom()));
      else if (kind < 3) begin
        send_item(pli_pkg::CMD_RESERVED, $signed($urandom()), $signed($urandom()));
      end
      else if (kind < 45) send_item(pli_pkg::CMD_INSERT, rand_word(), rand_word());
      else send_item(pli_pkg::CMD_QUERY, rand_word(), $signed($urandom()));
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(1550);
    if (errors == 0 && due_rd == due_wr) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
